@@ design/dadn_pkg.sv @@
// Package for the Gregorian date add-days unit.
// Holds widths, constants, the controller-to-datapath command and status types,
// and the month-length and leap-year functions. Depends on nothing.
package dadn_pkg;

    // Number of low bits of the offset field taken as the signed day offset.
    localparam int OFFSET_BITS = 16;

    // Field widths of the input and result items.
    localparam int DAY_IN_W  = 5;
    localparam int MONTH_W   = 4;
    localparam int YEAR_IN_W = 14;
    localparam int DOFS_W    = 16;

    // Bits of the offset field that are used, and whether they are signed.
    localparam int OFS_USE = (OFFSET_BITS < DOFS_W) ? OFFSET_BITS : DOFS_W;
    localparam bit OFS_SIGNED = (OFFSET_BITS <= DOFS_W);
    localparam logic [DOFS_W-1:0] OFS_MASK = {DOFS_W{1'b1}} >> (DOFS_W - OFS_USE);

    // Working day count, signed: start day plus the full offset range.
    localparam int DAY_W = DOFS_W + 2;
    // Working year, signed: can dip below zero.
    localparam int YR_W = YEAR_IN_W + 2;

    localparam int YEAR_CYCLE    = 400;
    localparam int CENTURY       = 100;
    localparam int YEAR_MIN      = 1;
    localparam int YEAR_MAX      = 9999;
    localparam int YEAR_SAT_HIGH = 10000;

    // Binary reduction of the start year modulo 400: 400 * 2^k for k = 5 down to 0.
    localparam int MOD_STEPS = 6;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    localparam logic [DAY_IN_W-1:0] FEB_LEAP_DAYS = 5'd29;
    localparam logic [DAY_IN_W-1:0] FEB_DAYS      = 5'd28;
    localparam logic [DAY_IN_W-1:0] SHORT_DAYS    = 5'd30;
    localparam logic [DAY_IN_W-1:0] LONG_DAYS     = 5'd31;

    typedef struct packed {
        logic                 load;
        logic                 mod_step;
        logic [MOD_CNT_W-1:0] mod_idx;
        logic                 fwd;
        logic                 back;
        logic                 capture;
    } t_dp_cmd;

    typedef struct packed {
        logic need_fwd;
        logic need_back;
    } t_dp_sts;

    // Leap test from the year's two low bits and its residue modulo 400.
    function automatic logic is_leap(input logic [1:0] low2, input logic [YEAR_IN_W-1:0] y400);
        logic div100;
        div100 = (y400 == YEAR_IN_W'(0)) || (y400 == YEAR_IN_W'(CENTURY)) ||
                 (y400 == YEAR_IN_W'(2 * CENTURY)) || (y400 == YEAR_IN_W'(3 * CENTURY));
        return (low2 == 2'd0) && (!div100 || (y400 == YEAR_IN_W'(0)));
    endfunction

    function automatic logic [DAY_IN_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                      input logic leap);
        logic [DAY_IN_W-1:0] len;
        case (month)
            MON_FEB: len = leap ? FEB_LEAP_DAYS : FEB_DAYS;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = SHORT_DAYS;
            default: len = LONG_DAYS;
        endcase
        return len;
    endfunction

endpackage

@@ design/dadn_ctrl.sv @@
// Controller of the date add-days unit: sequences load, year reduction,
// month stepping and the result hand-off. Depends on dadn_pkg.
module dadn_ctrl
    import dadn_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_STEP,
        S_HOLD
    } t_state;

    t_state               r_state, n_state;
    logic [MOD_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic                 out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = MOD_CNT_W'(MOD_STEPS - 1);
                    n_state    = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                o_cmd.mod_idx  = r_cnt;
                if (r_cnt == '0) begin
                    n_state = S_STEP;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_STEP: begin
                if (i_sts.need_fwd) begin
                    o_cmd.fwd = 1'b1;
                end else if (i_sts.need_back) begin
                    o_cmd.back = 1'b1;
                end else if (out_free) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.capture) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ design/dadn_datapath.sv @@
// Datapath of the date add-days unit: working day, month and year registers,
// the year-modulo-400 residue, and the result register. Depends on dadn_pkg.
module dadn_datapath
    import dadn_pkg::*;
(
    input  logic                  i_clk,
    input  t_dp_cmd               i_cmd,
    input  logic [DAY_IN_W-1:0]   i_start_day,
    input  logic [MONTH_W-1:0]    i_start_month,
    input  logic [YEAR_IN_W-1:0]  i_start_year,
    input  logic [DOFS_W-1:0]     i_day_offset,
    output t_dp_sts               o_sts,
    output logic [DAY_IN_W-1:0]   o_result_day,
    output logic [MONTH_W-1:0]    o_result_month,
    output logic [YEAR_IN_W-1:0]  o_result_year,
    output logic                  o_out_of_range
);

    logic signed [DAY_W-1:0] r_day, n_day;
    logic [MONTH_W-1:0]      r_month, n_month;
    logic signed [YR_W-1:0]  r_year, n_year;
    logic [YEAR_IN_W-1:0]    r_y400, n_y400;

    logic [DAY_IN_W-1:0]     r_res_day;
    logic [MONTH_W-1:0]      r_res_month;
    logic [YEAR_IN_W-1:0]    r_res_year;
    logic                    r_res_oor;

    logic [DOFS_W-1:0]       ofs_masked;
    logic signed [DAY_W-1:0] ofs_ext;
    logic [MONTH_W-1:0]      month_clamp;
    logic [DAY_IN_W-1:0]     cur_len;
    logic [DAY_IN_W-1:0]     prev_len;
    logic [MONTH_W-1:0]      prev_month;
    logic                    prev_wrap;
    logic [1:0]              prev_low2;
    logic [YEAR_IN_W-1:0]    prev_y400;
    logic [YEAR_IN_W-1:0]    next_y400;
    logic [YEAR_IN_W-1:0]    mod_thresh;
    logic                    year_low;
    logic                    year_high;

    // The offset keeps its low bits and is sign-extended from the top used bit.
    always_comb begin
        ofs_masked = i_day_offset & OFS_MASK;
        ofs_ext    = signed'(DAY_W'(ofs_masked));
        if (OFS_SIGNED && ofs_masked[OFS_USE-1]) begin
            ofs_ext = ofs_ext - signed'(DAY_W'(1) << OFS_USE);
        end
    end

    always_comb begin
        if (i_start_month < MON_JAN) begin
            month_clamp = MON_JAN;
        end else if (i_start_month > MON_DEC) begin
            month_clamp = MON_DEC;
        end else begin
            month_clamp = i_start_month;
        end
    end

    assign cur_len = month_len(r_month, is_leap(r_year[1:0], r_y400));

    // Stepping back from January lands in December of the previous year.
    assign prev_wrap  = (r_month == MON_JAN);
    assign prev_month = prev_wrap ? MON_DEC : (r_month - 1'b1);
    assign prev_low2  = prev_wrap ? (r_year[1:0] - 2'd1) : r_year[1:0];
    assign prev_y400  = !prev_wrap ? r_y400 :
                        (r_y400 == '0) ? YEAR_IN_W'(YEAR_CYCLE - 1) : (r_y400 - 1'b1);
    assign next_y400  = (r_y400 == YEAR_IN_W'(YEAR_CYCLE - 1)) ? '0 : (r_y400 + 1'b1);
    assign prev_len   = month_len(prev_month, is_leap(prev_low2, prev_y400));

    assign mod_thresh = YEAR_IN_W'(YEAR_CYCLE << i_cmd.mod_idx);

    assign o_sts.need_fwd  = (r_day > signed'(DAY_W'(cur_len)));
    assign o_sts.need_back = (r_day < signed'(DAY_W'(1)));

    always_comb begin
        n_day   = r_day;
        n_month = r_month;
        n_year  = r_year;
        n_y400  = r_y400;
        if (i_cmd.load) begin
            n_day   = signed'(DAY_W'(i_start_day)) + ofs_ext;
            n_month = month_clamp;
            n_year  = signed'(YR_W'(i_start_year));
            n_y400  = i_start_year;
        end else if (i_cmd.mod_step) begin
            if (r_y400 >= mod_thresh) begin
                n_y400 = r_y400 - mod_thresh;
            end
        end else if (i_cmd.fwd) begin
            n_day = r_day - signed'(DAY_W'(cur_len));
            if (r_month == MON_DEC) begin
                n_month = MON_JAN;
                n_year  = r_year + signed'(YR_W'(1));
                n_y400  = next_y400;
            end else begin
                n_month = r_month + 1'b1;
            end
        end else if (i_cmd.back) begin
            n_day   = r_day + signed'(DAY_W'(prev_len));
            n_month = prev_month;
            n_y400  = prev_y400;
            if (prev_wrap) begin
                n_year = r_year - signed'(YR_W'(1));
            end
        end
    end

    assign year_low  = (r_year < signed'(YR_W'(YEAR_MIN)));
    assign year_high = (r_year > signed'(YR_W'(YEAR_MAX)));

    always_ff @(posedge i_clk) begin
        r_day   <= n_day;
        r_month <= n_month;
        r_year  <= n_year;
        r_y400  <= n_y400;
        if (i_cmd.capture) begin
            r_res_day   <= r_day[DAY_IN_W-1:0];
            r_res_month <= r_month;
            r_res_oor   <= year_low || year_high;
            if (year_low) begin
                r_res_year <= '0;
            end else if (year_high) begin
                r_res_year <= YEAR_IN_W'(YEAR_SAT_HIGH);
            end else begin
                r_res_year <= r_year[YEAR_IN_W-1:0];
            end
        end
    end

    assign o_result_day   = r_res_day;
    assign o_result_month = r_res_month;
    assign o_result_year  = r_res_year;
    assign o_out_of_range = r_res_oor;

endmodule

@@ design/date_add_days_normalize_unit.sv @@
// Top level of the Gregorian date add-days unit: stream ports, controller
// and datapath. Depends on dadn_pkg, dadn_ctrl and dadn_datapath.
//
// Adds a signed day offset to a Gregorian date and returns the normalized
// date, stepping one month per clock cycle through the datapath. An item is
// accepted, its start year is reduced modulo 400, the day count is stepped
// through each month crossed, and the result register is written; the input
// is not ready again until that result has been written. A waiting result
// does not block the next transaction from being accepted. The out_of_range
// bit is set when the result year leaves 1..9999, with the year then reading
// 0 or 10000.
module date_add_days_normalize_unit
    import dadn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [4:0] start_day, [8:5] start_month, [22:9] start_year,
    // [38:23] day_offset, [39] zero pad.
    input  logic [39:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [4:0] result_day, [8:5] result_month, [22:9] result_year,
    // [23] out_of_range.
    output logic [23:0] o_m_axis_tdata
);

    t_dp_cmd              cmd;
    t_dp_sts              sts;
    logic [DAY_IN_W-1:0]  res_day;
    logic [MONTH_W-1:0]   res_month;
    logic [YEAR_IN_W-1:0] res_year;
    logic                 res_oor;

    dadn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    dadn_datapath u_datapath (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .i_start_day    (i_s_axis_tdata[4:0]),
        .i_start_month  (i_s_axis_tdata[8:5]),
        .i_start_year   (i_s_axis_tdata[22:9]),
        .i_day_offset   (i_s_axis_tdata[38:23]),
        .o_sts          (sts),
        .o_result_day   (res_day),
        .o_result_month (res_month),
        .o_result_year  (res_year),
        .o_out_of_range (res_oor)
    );

    assign o_m_axis_tdata = {res_oor, res_year, res_month, res_day};

endmodule
